/* src/cerl_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cerl_pkg: shared types and constants of the cross-entropy row loss block
// Command struct, controller states, status codes, register indexes and the
// ln(1+x) lookup table used by the log datapath.
// ----------------------------------------------------------------------------
package cerl_pkg;

  // field widths fixed by the stream format
  localparam int CLASS_W    = 10;
  localparam int COUNT_W    = 11;
  localparam int LOSS_W     = 20;
  localparam int STATUS_W   = 2;
  localparam int OUT_DATA_W = 24;
  localparam int CFG_IDX_W  = 1;

  // register indexes on the config port
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_MODE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_CLASS_COUNT = 1'b1;

  // target modes
  localparam logic MODE_SPARSE  = 1'b0;
  localparam logic MODE_ONE_HOT = 1'b1;

  // row status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_INDEX = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NO_HOT    = 2'd2;
  localparam logic [STATUS_W-1:0] ST_MULTI_HOT = 2'd3;

  // log arithmetic
  localparam int             TBL_W    = 16;
  localparam int             TIDX_W   = 5;
  localparam int             TFRAC_W  = 16;
  localparam int             DIFF_W   = 11;
  localparam int             PROD_W   = DIFF_W + TFRAC_W;
  localparam int             BIG_W    = 22;
  localparam logic [TBL_W-1:0]  LN2_Q16  = 16'd45426;
  localparam logic [LOSS_W-1:0] LOSS_MAX = 20'hFFFFF;

  // round(ln(1 + i/32) * 65536), i = 0..32
  localparam logic [TBL_W-1:0] LN_TABLE [0:32] = '{
    16'd0,     16'd2017,  16'd3973,  16'd5873,  16'd7719,  16'd9515,
    16'd11262, 16'd12965, 16'd14624, 16'd16242, 16'd17821, 16'd19364,
    16'd20870, 16'd22343, 16'd23783, 16'd25193, 16'd26573, 16'd27924,
    16'd29248, 16'd30546, 16'd31818, 16'd33067, 16'd34292, 16'd35494,
    16'd36675, 16'd37835, 16'd38975, 16'd40095, 16'd41196, 16'd42280,
    16'd43345, 16'd44394, 16'd45426
  };

  // controller states
  typedef enum logic [1:0] {
    S_COLLECT,
    S_NORM,
    S_MUL,
    S_SUM
  } state_t;

  // controller to datapath commands
  typedef struct packed {
    logic take;      // input request accepted this cycle
    logic norm_en;   // load normalize stage
    logic mul_en;    // load table and multiply stage
    logic out_load;  // load output payload
  } ctrl_cmd_t;

endpackage
`default_nettype wire

/* src/cerl_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cerl_ctrl: sequencing controller
// Collects a row one request per cycle, then steps the log datapath through
// its three stages and hands the result to the output register.
// ----------------------------------------------------------------------------
module cerl_ctrl
  import cerl_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic s_tvalid,
  input  wire logic s_tlast,
  output logic      s_tready,
  output logic      m_tvalid,
  input  wire logic m_tready,
  output ctrl_cmd_t cmd
);

  state_t state, state_next;
  logic   out_valid;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_COLLECT;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next   = state;
    s_tready     = 1'b0;
    cmd          = '0;
    unique case (state)
      S_COLLECT: begin
        // input stays closed while in reset
        s_tready = ~rst;
        cmd.take = s_tvalid & ~rst;
        if (cmd.take && s_tlast) begin
          state_next = S_NORM;
        end
      end
      S_NORM: begin
        cmd.norm_en = 1'b1;
        state_next  = S_MUL;
      end
      S_MUL: begin
        cmd.mul_en = 1'b1;
        state_next = S_SUM;
      end
      S_SUM: begin
        // wait until the output register is free
        if (!out_valid || m_tready) begin
          cmd.out_load = 1'b1;
          state_next   = S_COLLECT;
        end
      end
      default: state_next = S_COLLECT;
    endcase
  end

  // output valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= cmd.out_load | (out_valid & ~m_tready);
    end
  end

  assign m_tvalid = out_valid;

  // a pending result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || m_tready))
    else $error("result overwritten while pending");

  // row end closes the input until the log is done
  a_row_end_stall: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && s_tlast) |=> !s_tready)
    else $error("input open during log computation");

  // a loaded result shows as valid next cycle
  a_load_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |=> m_tvalid)
    else $error("loaded result not presented");

endmodule
`default_nettype wire

/* src/cerl_row.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cerl_row: row tracking datapath
// Counts columns, picks the true-class prediction and works out the row
// status; at row end it latches both and clears for the next row.
// ----------------------------------------------------------------------------
module cerl_row
  import cerl_pkg::*;
#(
  parameter int MAX_CLASSES    = 1024,
  parameter int PROB_FRAC_BITS = 16
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      take,
  input  wire logic                      target_mode,
  input  wire logic [COUNT_W-1:0]        class_count,
  input  wire logic [PROB_FRAC_BITS:0]   probability,
  input  wire logic [CLASS_W-1:0]        true_class,
  input  wire logic                      hot_bit,
  input  wire logic                      row_end,
  output logic      [PROB_FRAC_BITS:0]   fin_prob,
  output logic      [STATUS_W-1:0]       fin_status
);

  localparam int PW = $clog2(MAX_CLASSES + 1);
  localparam int EW = (PW > COUNT_W) ? PW : COUNT_W;

  logic [PW-1:0]             column_position;
  logic [PROB_FRAC_BITS:0]   chosen_probability;
  logic                      chosen_valid;
  logic [1:0]                hot_seen;
  logic [CLASS_W-1:0]        row_target;

  logic [PROB_FRAC_BITS:0]   chosen_probability_next;
  logic                      chosen_valid_next;
  logic [1:0]                hot_seen_next;
  logic [CLASS_W-1:0]        row_target_next;
  logic [PW-1:0]             column_position_next;
  logic [EW-1:0]             eff;
  logic [EW-1:0]             col_e;
  logic [EW-1:0]             tgt_e;
  logic                      in_range;
  logic [STATUS_W-1:0]       status;

  // effective class count and compare operands
  always_comb begin
    eff   = (EW'(class_count) > EW'(MAX_CLASSES)) ? EW'(MAX_CLASSES) : EW'(class_count);
    col_e = EW'(column_position);
  end

  // per-item update
  always_comb begin
    row_target_next         = (column_position == '0) ? true_class : row_target;
    tgt_e                   = EW'(row_target_next);
    in_range                = col_e < eff;
    chosen_probability_next = chosen_probability;
    chosen_valid_next       = chosen_valid;
    hot_seen_next           = hot_seen;
    if (in_range) begin
      if (target_mode == MODE_SPARSE) begin
        if (col_e == tgt_e) begin
          chosen_probability_next = probability;
          chosen_valid_next       = 1'b1;
        end
      end else if (hot_bit) begin
        if (hot_seen == 2'd0) begin
          chosen_probability_next = probability;
          chosen_valid_next       = 1'b1;
        end
        if (hot_seen < 2'd2) begin
          hot_seen_next = hot_seen + 2'd1;
        end
      end
    end
    // column count saturates at the maximum
    column_position_next = column_position;
    if (EW'(column_position) < EW'(MAX_CLASSES)) begin
      column_position_next = column_position + PW'(1);
    end
  end

  // row status at row end
  always_comb begin
    status = ST_OK;
    if (target_mode == MODE_SPARSE) begin
      if (tgt_e >= eff || !chosen_valid_next) begin
        status = ST_BAD_INDEX;
      end
    end else begin
      if (hot_seen_next == 2'd0) begin
        status = ST_NO_HOT;
      end else if (hot_seen_next >= 2'd2) begin
        status = ST_MULTI_HOT;
      end else if (!chosen_valid_next) begin
        status = ST_NO_HOT;
      end
    end
  end

  // row state
  always_ff @(posedge clk) begin
    if (rst) begin
      column_position    <= '0;
      chosen_probability <= '0;
      chosen_valid       <= 1'b0;
      hot_seen           <= 2'd0;
      row_target         <= '0;
    end else if (take) begin
      if (row_end) begin
        column_position    <= '0;
        chosen_probability <= '0;
        chosen_valid       <= 1'b0;
        hot_seen           <= 2'd0;
        row_target         <= '0;
      end else begin
        column_position    <= column_position_next;
        chosen_probability <= chosen_probability_next;
        chosen_valid       <= chosen_valid_next;
        hot_seen           <= hot_seen_next;
        row_target         <= row_target_next;
      end
    end
  end

  // latched row outcome for the log stages
  always_ff @(posedge clk) begin
    if (take && row_end) begin
      fin_prob   <= chosen_probability_next;
      fin_status <= status;
    end
  end

endmodule
`default_nettype wire

/* src/cerl_log.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cerl_log: -ln(p) datapath
// Three stages: clip and leading-one search; normalize, table read and
// interpolation multiply; combine with the exponent term and saturate.
// ----------------------------------------------------------------------------
module cerl_log
  import cerl_pkg::*;
#(
  parameter int PROB_FRAC_BITS = 16
) (
  input  wire logic                    clk,
  input  wire logic                    norm_en,
  input  wire logic                    mul_en,
  input  wire logic                    out_load,
  input  wire logic [PROB_FRAC_BITS:0] fin_prob,
  input  wire logic [STATUS_W-1:0]     fin_status,
  output logic      [LOSS_W-1:0]       loss_value,
  output logic      [STATUS_W-1:0]     row_status
);

  localparam int PFB = PROB_FRAC_BITS;
  localparam int MW  = $clog2(PFB);
  localparam int FW  = PFB - 1;
  localparam int NW  = (FW > TIDX_W + TFRAC_W) ? FW : TIDX_W + TFRAC_W;
  localparam logic [PFB:0] ONE = (PFB + 1)'(1) << PFB;

  // stage 1 signals
  logic [PFB:0]          pc;
  logic [MW-1:0]         lead;
  logic [PFB-1:0]        n_p;
  logic [MW-1:0]         n_m;
  logic                  n_zero;
  logic [STATUS_W-1:0]   n_status;

  // stage 2 signals
  logic [MW-1:0]         sh;
  logic [PFB-1:0]        x;
  logic [NW-1:0]         fw;
  logic [TIDX_W-1:0]     idx;
  logic [TFRAC_W-1:0]    t;
  logic [TBL_W-1:0]      base;
  logic [TBL_W-1:0]      diff;
  logic [TBL_W-1:0]      m_base;
  logic [PROD_W-1:0]     m_prod;
  logic [MW-1:0]         m_m;
  logic                  m_zero;
  logic [STATUS_W-1:0]   m_status;

  // stage 3 signals
  logic [MW:0]           scale;
  logic [BIG_W-1:0]      v;
  logic [BIG_W-1:0]      big;
  logic [LOSS_W-1:0]     loss_next;

  // clip 0 and 1.0 into [1 LSB, 1 - 1 LSB] and find the leading one
  always_comb begin
    pc = fin_prob;
    if (fin_prob == '0) begin
      pc = (PFB + 1)'(1);
    end else if (fin_prob == ONE) begin
      pc = ONE - (PFB + 1)'(1);
    end
    lead = '0;
    for (int k = 0; k < PFB; k++) begin
      if (pc[k]) begin
        lead = MW'(k);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (norm_en) begin
      n_p      <= pc[PFB-1:0];
      n_m      <= lead;
      n_zero   <= (fin_prob > ONE) || (fin_status != ST_OK);
      n_status <= fin_status;
    end
  end

  // normalize, read table, interpolation product
  always_comb begin
    sh   = MW'(PFB - 1) - n_m;
    x    = n_p << sh;
    fw   = NW'(x[FW-1:0]) << (NW - FW);
    idx  = fw[NW-1 -: TIDX_W];
    t    = fw[NW-1-TIDX_W -: TFRAC_W];
    base = LN_TABLE[{1'b0, idx}];
    diff = LN_TABLE[{1'b0, idx} + 6'd1] - base;
  end

  always_ff @(posedge clk) begin
    if (mul_en) begin
      m_base   <= base;
      m_prod   <= diff[DIFF_W-1:0] * t;
      m_m      <= n_m;
      m_zero   <= n_zero;
      m_status <= n_status;
    end
  end

  // exponent term minus fraction log, saturated
  always_comb begin
    scale = (MW + 1)'(PFB) - {1'b0, m_m};
    v     = BIG_W'(m_base) + BIG_W'(m_prod[PROD_W-1:TFRAC_W]);
    big   = BIG_W'(scale) * BIG_W'(LN2_Q16) - v;
    if (m_zero) begin
      loss_next = '0;
    end else if (big > BIG_W'(LOSS_MAX)) begin
      loss_next = LOSS_MAX;
    end else begin
      loss_next = big[LOSS_W-1:0];
    end
  end

  // output payload register
  always_ff @(posedge clk) begin
    if (out_load) begin
      loss_value <= loss_next;
      row_status <= m_status;
    end
  end

endmodule
`default_nettype wire

/* src/cross_entropy_row_loss_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cross_entropy_row_loss_top: per-row categorical cross-entropy loss
// Streams class probabilities a row at a time and returns -ln(p) of the
// true class in Q4.16 with a row status.
// ----------------------------------------------------------------------------
//  channel | dir | handshake          | payload
//  s_*     | in  | s_tvalid/s_tready  | tdata: probability, true_class
//          |     |                    | tuser: hot_bit; tlast: row_end
//  m_*     | out | m_tvalid/m_tready  | tdata: loss_value; tuser: row_status
//  cfg_*   | in  | cfg_valid/cfg_ready| cfg_index, cfg_data
//
//  One request per cycle inside a row; after the row-end request the input
//  closes while the log datapath steps through its normalize, multiply and
//  sum states and reopens when the result goes into the output register.
//  The result waits in an output register; the next row is collected while
//  it waits, and the log stage holds at its last step if it is still unread.
//  rst is synchronous and clears the row state and config to defaults.
// ----------------------------------------------------------------------------
module cross_entropy_row_loss_top
  import cerl_pkg::*;
#(
  parameter int MAX_CLASSES    = 1024,
  parameter int PROB_FRAC_BITS = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  // input stream
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  input  wire logic [((PROB_FRAC_BITS+1+CLASS_W+7)/8)*8-1:0] s_tdata,
    // probability, true_class, zero pad
  input  wire logic                 s_tuser,   // hot_bit
  input  wire logic                 s_tlast,   // row_end
  // result stream
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  output logic [OUT_DATA_W-1:0]     m_tdata,   // loss_value, zero pad
  output logic [STATUS_W-1:0]       m_tuser,   // row_status
  // config writes
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [COUNT_W-1:0]   cfg_data
);

  localparam int PFB = PROB_FRAC_BITS;

  ctrl_cmd_t           cmd;
  logic                target_mode;
  logic [COUNT_W-1:0]  class_count;
  logic [PFB:0]        fin_prob;
  logic [STATUS_W-1:0] fin_status;
  logic [LOSS_W-1:0]   loss_value;
  logic [STATUS_W-1:0] row_status;

  // config registers, closed while in reset
  assign cfg_ready = ~rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_mode <= MODE_SPARSE;
      class_count <= COUNT_W'(10);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_TARGET_MODE: target_mode <= cfg_data[0];
        CFG_CLASS_COUNT: class_count <= cfg_data;
        default: ;
      endcase
    end
  end

  cerl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tlast  (s_tlast),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd)
  );

  cerl_row #(
    .MAX_CLASSES    (MAX_CLASSES),
    .PROB_FRAC_BITS (PROB_FRAC_BITS)
  ) u_row (
    .clk         (clk),
    .rst         (rst),
    .take        (cmd.take),
    .target_mode (target_mode),
    .class_count (class_count),
    .probability (s_tdata[PFB:0]),
    .true_class  (s_tdata[PFB+CLASS_W:PFB+1]),
    .hot_bit     (s_tuser),
    .row_end     (s_tlast),
    .fin_prob    (fin_prob),
    .fin_status  (fin_status)
  );

  cerl_log #(
    .PROB_FRAC_BITS (PROB_FRAC_BITS)
  ) u_log (
    .clk        (clk),
    .norm_en    (cmd.norm_en),
    .mul_en     (cmd.mul_en),
    .out_load   (cmd.out_load),
    .fin_prob   (fin_prob),
    .fin_status (fin_status),
    .loss_value (loss_value),
    .row_status (row_status)
  );

  assign m_tdata = {(OUT_DATA_W - LOSS_W)'(0), loss_value};
  assign m_tuser = row_status;

endmodule
`default_nettype wire
